@@ hdl/ptc_pkg.sv @@
// Package for the perceptron train/classify block: payload structs, codes,
// fixed-point constants and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptc_pkg;

  // Default feature dimension.
  localparam int DIM_DEFAULT = 8;

  // Queue depths.
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_BIAS      = 4'd1;
  localparam logic [15:0] LR_RESET       = 16'd655;
  localparam logic        ADD_BIAS_RESET = 1'b1;

  // Item operation codes.
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_CLASSIFY = 2'd1;
  localparam logic [1:0] OP_TRAIN    = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  // Fixed-point constants: weights Q8.16, features Q8.8.
  localparam logic signed [23:0] W_MAX    = 24'sh7FFFFF;
  localparam logic signed [23:0] W_MIN    = -24'sh800000;
  localparam logic signed [15:0] ONE_Q8_8 = 16'sd256;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [23:0] value;
    logic [3:0]         weight_index;
    logic               last_element;
    logic               target;
  } in_item_t;

  typedef struct packed {
    logic class_out;
    logic weights_changed;
    logic sample_error;
  } out_item_t;

  typedef struct packed {
    logic [15:0] learning_rate;
    logic        add_bias;
  } cfg_t;

  typedef enum logic {
    CMD_LOAD,
    CMD_ELEM
  } cmd_kind_t;

  // Decoded command from the front to the back.
  typedef struct packed {
    cmd_kind_t          kind;
    logic               is_train;
    logic signed [23:0] value;
    logic [3:0]         weight_index;
    logic               last;
    logic               target;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ACC,
    ST_BMUL,
    ST_BACC,
    ST_UMUL,
    ST_UWR,
    ST_RES
  } back_state_t;

endpackage

`default_nettype wire

@@ hdl/ptc_fifo.sv @@
// Small synchronous FIFO of a generic payload type, used for the command
// queue and the result queue. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module ptc_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire T     wdata,
  output logic      full,
  input  wire logic pop,
  output T          rdata,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ptc_front.sv @@
// Front end: accepts input transactions, decodes the operation and queues
// commands for the back end. Depends on ptc_pkg and ptc_fifo.
`timescale 1ns / 1ps
`default_nettype none

module ptc_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire ptc_pkg::in_item_t in_data,
  output logic                  in_full,
  input  wire logic             cmd_pop,
  output ptc_pkg::cmd_t         cmd_data,
  output logic                  cmd_empty
);

  ptc_pkg::cmd_t cmd_dec;
  logic          cmd_keep;

  // The unused operation is accepted and dropped here.
  always_comb begin
    cmd_dec.kind         = ptc_pkg::CMD_ELEM;
    cmd_dec.is_train     = 1'b0;
    cmd_dec.value        = in_data.value;
    cmd_dec.weight_index = in_data.weight_index;
    cmd_dec.last         = in_data.last_element;
    cmd_dec.target       = in_data.target;
    cmd_keep             = 1'b1;
    unique case (in_data.op)
      ptc_pkg::OP_LOAD: begin
        cmd_dec.kind = ptc_pkg::CMD_LOAD;
      end
      ptc_pkg::OP_CLASSIFY: begin
        cmd_dec.is_train = 1'b0;
      end
      ptc_pkg::OP_TRAIN: begin
        cmd_dec.is_train = 1'b1;
      end
      ptc_pkg::OP_UNUSED: begin
        cmd_keep = 1'b0;
      end
    endcase
  end

  ptc_fifo #(
    .T     (ptc_pkg::cmd_t),
    .DEPTH (ptc_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && cmd_keep),
    .wdata (cmd_dec),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_data),
    .empty (cmd_empty)
  );

endmodule

`default_nettype wire

@@ hdl/ptc_back.sv @@
// Back end: sequencer holding the weight store and sample buffer, one multiply
// step per element, bias term, decision and weight update loop.
// Depends on ptc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptc_back #(
  parameter int DIM = ptc_pkg::DIM_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ptc_pkg::cfg_t  cfg,
  input  wire ptc_pkg::cmd_t  cmd_in,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  output ptc_pkg::out_item_t  res_data,
  output logic                res_push,
  input  wire logic           res_full
);

  localparam int AW    = $clog2(DIM + 1);
  localparam int CW    = $clog2(DIM + 3);
  localparam int IW    = (AW > 4) ? AW : 4;
  localparam int ACC_W = 41 + $clog2(DIM + 1);

  ptc_pkg::back_state_t state_r, state_nxt;
  ptc_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic signed [ACC_W-1:0] sum_r, sum_nxt;
  logic signed [39:0]   prod_r, prod_nxt;
  logic signed [33:0]   upd_r, upd_nxt;
  logic                 use_r, use_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic                 guess_r, guess_nxt;
  logic                 changed_r, changed_nxt;
  logic                 serr_r, serr_nxt;

  // Weight store with a valid bit per entry; an unwritten entry reads zero.
  logic signed [23:0]   wmem [DIM+1];
  logic [DIM:0]         wvalid_r;
  logic signed [23:0]   w_rdata_r;
  logic                 w_rvalid_r;
  logic                 w_we;
  logic [AW-1:0]        w_waddr;
  logic signed [23:0]   w_wdata;

  logic signed [15:0]   sbuf [DIM+1];
  logic signed [15:0]   s_rdata_r;
  logic                 s_we;
  logic [AW-1:0]        s_waddr;

  logic [AW-1:0]        raddr;

  logic                 pos_in, pos_use;
  logic [AW-1:0]        pos_addr;
  logic [IW-1:0]        load_idx;
  logic                 load_ok;
  logic signed [23:0]   w_rd;
  logic signed [15:0]   feat, bias_in, xi;
  logic signed [ACC_W-1:0] sum_fin;
  logic [CW-1:0]        expected;
  logic [17:0]          scale_mag;
  logic signed [17:0]   scale;
  logic signed [33:0]   rnd;
  logic signed [25:0]   delta;
  logic signed [26:0]   nw_wide;
  logic signed [23:0]   nw_sat;

  assign pos_in   = (count_r <= CW'(DIM));
  assign pos_use  = (count_r < CW'(DIM));
  assign pos_addr = pos_in ? count_r[AW-1:0] : '0;
  assign load_idx = IW'(cmd_in.weight_index);
  assign load_ok  = (load_idx <= IW'(DIM));
  assign w_rd     = w_rvalid_r ? w_rdata_r : '0;
  assign feat     = $signed(cmd_r.value[15:0]);
  assign sum_fin  = sum_r + ACC_W'(prod_r);
  assign expected = (!cmd_r.is_train && !cfg.add_bias) ? CW'(DIM + 1) : CW'(DIM);

  // The bias is one for train or add_bias, else the last slot if filled, or zero.
  always_comb begin
    if (cmd_r.is_train || cfg.add_bias) begin
      bias_in = ptc_pkg::ONE_Q8_8;
    end else if (count_r > CW'(DIM)) begin
      bias_in = s_rdata_r;
    end else begin
      bias_in = '0;
    end
  end

  // Update step: (target - guess) is +2 or -2 when the guess was wrong.
  assign scale_mag = {1'b0, cfg.learning_rate, 1'b0};
  assign scale     = cmd_r.target ? $signed(scale_mag) : -$signed(scale_mag);

  always_comb begin
    if (idx_r == AW'(DIM)) begin
      xi = ptc_pkg::ONE_Q8_8;
    end else if (CW'(idx_r) < count_r) begin
      xi = s_rdata_r;
    end else begin
      xi = '0;
    end
  end

  // Round to Q8.16 (add half, floor) and saturate.
  assign rnd     = upd_r + 34'sd128;
  assign delta   = $signed(rnd[33:8]);
  assign nw_wide = 27'(w_rd) + 27'(delta);

  always_comb begin
    if (nw_wide > 27'(ptc_pkg::W_MAX)) begin
      nw_sat = ptc_pkg::W_MAX;
    end else if (nw_wide < 27'(ptc_pkg::W_MIN)) begin
      nw_sat = ptc_pkg::W_MIN;
    end else begin
      nw_sat = nw_wide[23:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    count_nxt   = count_r;
    sum_nxt     = sum_r;
    prod_nxt    = prod_r;
    upd_nxt     = upd_r;
    use_nxt     = use_r;
    idx_nxt     = idx_r;
    guess_nxt   = guess_r;
    changed_nxt = changed_r;
    serr_nxt    = serr_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    w_we        = 1'b0;
    w_waddr     = '0;
    w_wdata     = cmd_in.value;
    s_we        = 1'b0;
    s_waddr     = pos_addr;
    raddr       = '0;

    unique case (state_r)
      ptc_pkg::ST_IDLE: begin
        raddr = pos_addr;
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (cmd_in.kind)
            ptc_pkg::CMD_LOAD: begin
              w_we    = load_ok;
              w_waddr = load_idx[AW-1:0];
            end
            ptc_pkg::CMD_ELEM: begin
              cmd_nxt   = cmd_in;
              s_we      = pos_in;
              use_nxt   = pos_use;
              state_nxt = ptc_pkg::ST_MAC;
              if (count_r < CW'(DIM + 2)) begin
                count_nxt = count_r + 1'b1;
              end
            end
          endcase
        end
      end
      ptc_pkg::ST_MAC: begin
        prod_nxt  = use_r ? 40'(w_rd) * 40'(feat) : '0;
        state_nxt = ptc_pkg::ST_ACC;
      end
      ptc_pkg::ST_ACC: begin
        sum_nxt   = sum_fin;
        raddr     = AW'(DIM);
        state_nxt = cmd_r.last ? ptc_pkg::ST_BMUL : ptc_pkg::ST_IDLE;
      end
      ptc_pkg::ST_BMUL: begin
        raddr     = AW'(DIM);
        prod_nxt  = 40'(w_rd) * 40'(bias_in);
        state_nxt = ptc_pkg::ST_BACC;
      end
      ptc_pkg::ST_BACC: begin
        raddr       = '0;
        idx_nxt     = '0;
        guess_nxt   = (sum_fin > 0);
        serr_nxt    = (count_r != expected);
        changed_nxt = cmd_r.is_train && ((sum_fin > 0) != cmd_r.target);
        state_nxt   = changed_nxt ? ptc_pkg::ST_UMUL : ptc_pkg::ST_RES;
      end
      ptc_pkg::ST_UMUL: begin
        raddr     = idx_r;
        upd_nxt   = scale * xi;
        state_nxt = ptc_pkg::ST_UWR;
      end
      ptc_pkg::ST_UWR: begin
        w_we    = 1'b1;
        w_waddr = idx_r;
        w_wdata = nw_sat;
        // Fetch the next entry while this one is written back.
        raddr   = (idx_r == AW'(DIM)) ? '0 : idx_r + 1'b1;
        if (idx_r == AW'(DIM)) begin
          state_nxt = ptc_pkg::ST_RES;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ptc_pkg::ST_UMUL;
        end
      end
      ptc_pkg::ST_RES: begin
        if (!res_full) begin
          res_push  = 1'b1;
          count_nxt = '0;
          sum_nxt   = '0;
          state_nxt = ptc_pkg::ST_IDLE;
        end
      end
    endcase
  end

  assign res_data.class_out       = guess_r;
  assign res_data.weights_changed = changed_r;
  assign res_data.sample_error    = serr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ptc_pkg::ST_IDLE;
      count_r  <= '0;
      sum_r    <= '0;
      wvalid_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      if (w_we) begin
        wvalid_r[w_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    prod_r    <= prod_nxt;
    upd_r     <= upd_nxt;
    use_r     <= use_nxt;
    idx_r     <= idx_nxt;
    guess_r   <= guess_nxt;
    changed_r <= changed_nxt;
    serr_r    <= serr_nxt;
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    w_rdata_r  <= wmem[raddr];
    w_rvalid_r <= wvalid_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sbuf[s_waddr] <= $signed(cmd_in.value[15:0]);
    end
    s_rdata_r <= sbuf[raddr];
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DIM + 2))
    else $error("element count beyond its saturation value");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (count_r == '0 && sum_r == '0))
    else $error("sample state not cleared after a result");

  a_loop_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptc_pkg::ST_UWR && idx_r == AW'(DIM)) |=> state_r == ptc_pkg::ST_RES)
    else $error("update loop did not finish at the bias weight");

  a_elem_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd_in.kind == ptc_pkg::CMD_ELEM) |=> state_r == ptc_pkg::ST_MAC)
    else $error("element command did not start a multiply step");

endmodule

`default_nettype wire

@@ hdl/perceptron_train_classify.sv @@
// Result path: a sample's last element passes MAC, ACC, BMUL and BACC, then UMUL and
// UWR for each of the DIM+1 weights if a train sample updates them, then RES queues
// the result. Flow: the back end does a weight read, multiply and accumulate per
// feature, writes loads from idle and takes commands only in idle; the front queues
// up to 4 items at one per cycle unless full. Reset: synchronous, active low; all
// weights read zero at once, registers reset, queues empty. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module perceptron_train_classify #(
  parameter int DIM = ptc_pkg::DIM_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  input  wire ptc_pkg::in_item_t                 in_data,
  output logic                                   in_full,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output ptc_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ptc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ptc_pkg::cfg_t      cfg_r;
  ptc_pkg::cmd_t      cmd_data;
  logic               cmd_empty;
  logic               cmd_pop;
  ptc_pkg::out_item_t res_data;
  logic               res_push;
  logic               res_full;

  assign cfg_ready = 1'b1;

  // Writes to indexes outside the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.learning_rate <= ptc_pkg::LR_RESET;
      cfg_r.add_bias      <= ptc_pkg::ADD_BIAS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ptc_pkg::CFG_LEARNING_RATE) begin
        cfg_r.learning_rate <= cfg_data;
      end else if (cfg_index == ptc_pkg::CFG_ADD_BIAS) begin
        cfg_r.add_bias <= cfg_data[0];
      end
    end
  end

  ptc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data),
    .cmd_empty (cmd_empty)
  );

  ptc_back #(
    .DIM (DIM)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_in    (cmd_data),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_data  (res_data),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  ptc_fifo #(
    .T     (ptc_pkg::out_item_t),
    .DEPTH (ptc_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

`default_nettype wire

@@ bench/perceptron_train_classify_tb.sv @@
// Self-checking bench for perceptron_train_classify: load, classify and train
// transactions against a bit-accurate predictor of the weights and decisions.
// Depends on ptc_pkg (payload structs, op codes, register indexes) and the RTL top.
`timescale 1ns / 1ps

module perceptron_train_classify_tb;

  localparam int DIM              = ptc_pkg::DIM_DEFAULT;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 60;
  localparam int HOLD_CYCLES      = 300;
  localparam int HOLD_AT_DECISION = 12;
  localparam int SIDE_SEND        = 0;
  localparam int SIDE_RECV        = 1;

  // Tracks the weight store and the sample in progress, and queues the
  // decision that each completed sample must produce.
  class perceptron_tracker;
    longint    weights [DIM+1];
    longint    feat_buf [DIM+1];
    int        elem_count;
    longint    dot_acc;
    int unsigned rate;
    bit        bias_const;
    ptc_pkg::out_item_t pending_decisions [$];
    int        mismatches;
    int        items_taken;
    int        decisions_checked;
    int        updates_seen;
    int        length_errors;

    function new();
      foreach (weights[i]) weights[i] = 0;
      foreach (feat_buf[i]) feat_buf[i] = 0;
      elem_count = 0;
      dot_acc = 0;
      rate = 32'(ptc_pkg::LR_RESET);
      bias_const = ptc_pkg::ADD_BIAS_RESET;
    endfunction

    function void set_register(logic [ptc_pkg::CFG_IDX_W-1:0] idx,
                               logic [ptc_pkg::CFG_DATA_W-1:0] data);
      if (idx == ptc_pkg::CFG_LEARNING_RATE) rate = 32'(data);
      else if (idx == ptc_pkg::CFG_ADD_BIAS) bias_const = data[0];
    endfunction

    // Q8.24 update to Q8.16, rounding half up.
    static function longint to_q16(longint p);
      return (p + 128) >>> 8;
    endfunction

    static function longint clamp_weight(longint w);
      if (w > longint'(ptc_pkg::W_MAX)) return longint'(ptc_pkg::W_MAX);
      if (w < longint'(ptc_pkg::W_MIN)) return longint'(ptc_pkg::W_MIN);
      return w;
    endfunction

    function void accept_item(ptc_pkg::in_item_t it);
      longint    x, bias_in, total, upd_scale, xi;
      int        expected_len, n, i;
      bit        is_train, guess, changed;
      ptc_pkg::out_item_t d;
      items_taken++;
      if (it.op == ptc_pkg::OP_LOAD) begin
        if (it.weight_index <= DIM) weights[it.weight_index] = longint'(it.value);
        return;
      end
      if (it.op == ptc_pkg::OP_UNUSED) return;

      x = longint'($signed(it.value[15:0]));
      if (elem_count <= DIM) begin
        feat_buf[elem_count] = x;
        if (elem_count < DIM) dot_acc += weights[elem_count] * x;
      end
      if (elem_count < DIM + 2) elem_count++;
      if (!it.last_element) return;

      // The op of the closing element decides what kind of sample this was.
      is_train = (it.op == ptc_pkg::OP_TRAIN);
      if (is_train || bias_const) bias_in = longint'(ptc_pkg::ONE_Q8_8);
      else bias_in = (elem_count > DIM) ? feat_buf[DIM] : 0;
      expected_len = (!is_train && !bias_const) ? DIM + 1 : DIM;
      total = dot_acc + weights[DIM] * bias_in;
      guess = (total > 0);
      changed = 1'b0;

      if (is_train && guess != it.target) begin
        upd_scale = (it.target ? 2 : -2) * longint'(rate);
        n = (elem_count < DIM) ? elem_count : DIM;
        for (i = 0; i < DIM; i++) begin
          xi = (i < n) ? feat_buf[i] : 0;
          weights[i] = clamp_weight(weights[i] + to_q16(upd_scale * xi));
        end
        weights[DIM] = clamp_weight(weights[DIM] +
                                    to_q16(upd_scale * longint'(ptc_pkg::ONE_Q8_8)));
        changed = 1'b1;
      end

      d.class_out = guess;
      d.weights_changed = changed;
      d.sample_error = (elem_count != expected_len);
      pending_decisions.push_back(d);
      elem_count = 0;
      dot_acc = 0;
    endfunction

    task report_mismatch(string what);
      $display("tb: mismatch: %s", what);
      mismatches++;
    endtask

    task check_decision(ptc_pkg::out_item_t got);
      ptc_pkg::out_item_t want;
      if (pending_decisions.size() == 0) begin
        report_mismatch($sformatf("result %b arrived with none expected", got));
        return;
      end
      want = pending_decisions.pop_front();
      decisions_checked++;
      if (want.weights_changed) updates_seen++;
      if (want.sample_error) length_errors++;
      if (got.class_out !== want.class_out)
        report_mismatch($sformatf("decision %0d: class_out %b, expected %b",
                                  decisions_checked, got.class_out, want.class_out));
      if (got.weights_changed !== want.weights_changed)
        report_mismatch($sformatf("decision %0d: weights_changed %b, expected %b",
                                  decisions_checked, got.weights_changed,
                                  want.weights_changed));
      if (got.sample_error !== want.sample_error)
        report_mismatch($sformatf("decision %0d: sample_error %b, expected %b",
                                  decisions_checked, got.sample_error, want.sample_error));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_push;
  ptc_pkg::in_item_t  in_data;
  logic      in_full;
  logic      out_empty;
  logic      out_pop;
  ptc_pkg::out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_data;

  perceptron_tracker tracker;
  int cycles = 0;
  int streak_left [2] = '{0, 0};
  bit streak_quiet [2] = '{1'b0, 1'b0};

  perceptron_train_classify u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Each side mixes stretches with no idling and stretches of
  // random waits, so gaps land on every phase of the back end.
  function automatic int draw_gap(int side);
    if (streak_left[side] == 0) begin
      streak_left[side] = $urandom_range(10, 40);
      streak_quiet[side] = ($urandom_range(0, 2) == 0);
    end
    streak_left[side]--;
    return streak_quiet[side] ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic ptc_pkg::in_item_t make_item(logic [1:0] op, logic [23:0] value,
                                                  logic [3:0] idx, logic last, logic tgt);
    ptc_pkg::in_item_t it;
    it.op = op;
    it.value = value;
    it.weight_index = idx;
    it.last_element = last;
    it.target = tgt;
    return it;
  endfunction

  function automatic logic [23:0] pick_feature();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 24'h007FFF;
    if (r == 1) return 24'hFF8000;
    if (r < 5) return 24'($urandom);
    return 24'(int'($urandom_range(0, 2048)) - 1024);
  endfunction

  function automatic logic [23:0] pick_weight();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return ptc_pkg::W_MAX;
    if (r == 1) return ptc_pkg::W_MIN;
    if (r < 4) return 24'($urandom);
    return 24'(int'($urandom_range(0, 262144)) - 131072);
  endfunction

  // Ends at a falling edge with in_push still high, so back-to-back
  // transactions keep push asserted.
  task automatic push_item(ptc_pkg::in_item_t it);
    int gap;
    gap = draw_gap(SIDE_SEND);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    tracker.accept_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [ptc_pkg::CFG_IDX_W-1:0] idx,
                           logic [ptc_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(logic [15:0] lr, logic bias_one);
    write_reg(ptc_pkg::CFG_LEARNING_RATE, lr);
    write_reg(ptc_pkg::CFG_ADD_BIAS, {15'd0, bias_one});
    cfg_valid <= 1'b0;
  endtask

  // Loads and partial samples give no result, so after the last decision the
  // back end may still be busy; give it time before touching registers.
  task automatic settle();
    in_push <= 1'b0;
    while (tracker.pending_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_directed();
    int k;
    logic [23:0] x;
    push_item(make_item(ptc_pkg::OP_LOAD, ptc_pkg::W_MAX, 4'd0, 1'b0, 1'b0));
    push_item(make_item(ptc_pkg::OP_LOAD, ptc_pkg::W_MIN, 4'(DIM), 1'b1, 1'b1));
    // Slot above the bias: must be ignored.
    push_item(make_item(ptc_pkg::OP_LOAD, 24'h123456, 4'd15, 1'b0, 1'b0));
    push_item(make_item(ptc_pkg::OP_UNUSED, 24'hFFFFFF, 4'd3, 1'b1, 1'b1));
    // Full classify sample with extreme and oversized features, and a load
    // landing in the middle of it.
    for (k = 0; k < DIM; k++) begin
      if (k == 3) push_item(make_item(ptc_pkg::OP_LOAD, 24'h010000, 4'd2, 1'b0, 1'b0));
      x = (k == 0) ? 24'h007FFF : (k == 1) ? 24'hFF8000 : (k == 2) ? 24'hABCDEF
                                                                   : pick_feature();
      push_item(make_item(ptc_pkg::OP_CLASSIFY, x, 4'(k), k == DIM - 1, 1'b0));
    end
    // Short sample that opens as classify and closes as train.
    push_item(make_item(ptc_pkg::OP_CLASSIFY, 24'h000100, 4'd0, 1'b0, 1'b1));
    push_item(make_item(ptc_pkg::OP_TRAIN, 24'h000200, 4'd0, 1'b1, 1'b1));
    // Long train sample: the count saturates and the extra elements are dropped.
    for (k = 0; k < DIM + 2; k++)
      push_item(make_item(ptc_pkg::OP_TRAIN, pick_feature(), 4'($urandom_range(0, 15)),
                          k == DIM + 1, 1'b0));
  endtask

  // Mostly well-formed samples whose targets follow a fixed linear rule, with
  // odd lengths, mixed ops, stray loads and unused ops mixed in.
  task automatic run_random(int budget);
    int counted, len, expected_len, k, score, xs;
    logic [1:0] op, el_op;
    logic [3:0] idx;
    logic [23:0] x;
    bit tgt;
    counted = 0;
    while (counted < budget) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        idx = 4'($urandom_range(0, 15));
        push_item(make_item(ptc_pkg::OP_LOAD, pick_weight(), idx,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        if (idx <= DIM) counted++;
      end else if (k < 11) begin
        push_item(make_item(ptc_pkg::OP_UNUSED, 24'($urandom), 4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end else begin
        op = $urandom_range(0, 1) ? ptc_pkg::OP_TRAIN : ptc_pkg::OP_CLASSIFY;
        expected_len = (op == ptc_pkg::OP_CLASSIFY && !tracker.bias_const) ? DIM + 1 : DIM;
        len = ($urandom_range(0, 9) < 8) ? expected_len : $urandom_range(1, DIM + 4);
        score = 0;
        for (k = 0; k < len; k++) begin
          x = pick_feature();
          xs = int'($signed(x[15:0]));
          if (k < DIM) score += (k % 3 == 0) ? xs : (k % 3 == 1) ? -xs : 0;
          tgt = (score > 0) ^ ($urandom_range(0, 9) == 0);
          el_op = op;
          if ($urandom_range(0, 19) == 0)
            el_op = (op == ptc_pkg::OP_TRAIN) ? ptc_pkg::OP_CLASSIFY : ptc_pkg::OP_TRAIN;
          if ($urandom_range(0, 29) == 0) begin
            idx = 4'($urandom_range(0, DIM));
            push_item(make_item(ptc_pkg::OP_LOAD, pick_weight(), idx, 1'b0, 1'b0));
            counted++;
          end
          push_item(make_item(el_op, x, 4'($urandom_range(0, 15)), k == len - 1, tgt));
          counted++;
        end
      end
    end
  endtask

  // Result side; holds off once for a long stretch so the input queue fills.
  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!hold_done && tracker.decisions_checked >= HOLD_AT_DECISION) begin
        hold_done = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = draw_gap(SIDE_RECV);
        if (gap > 0) begin
          out_pop <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      tracker.check_decision(out_data);
      @(negedge clk);
    end
  end

  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(250);
    settle();
    apply_settings(16'hFFFF, 1'b0);
    run_random(250);
    settle();
    apply_settings(16'h0000, 1'b1);
    run_random(150);
    settle();
    apply_settings(16'($urandom_range(1, 65534)), 1'b0);
    run_random(200);
    settle();
    apply_settings(16'h0001, 1'b1);
    run_random(175);
    settle();

    $display("tb: %0d transactions accepted under five register settings, %0d decisions checked",
             tracker.items_taken, tracker.decisions_checked);
    $display("tb: %0d weight updates and %0d length errors among them, one %0d-cycle output stall",
             tracker.updates_seen, tracker.length_errors, HOLD_CYCLES);
    if (tracker.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
